FILE: rtl/core/lpclp_pkg.sv
// shared types, constants and rounding helper for the lidar label projector
`default_nettype none
package lpclp_pkg;

  localparam int unsigned ImageWidthDef  = 480;
  localparam int unsigned ImageHeightDef = 270;

  localparam int unsigned CoordW  = 18;
  localparam int unsigned TrigW   = 16;
  localparam int unsigned PixW    = 9;
  localparam int unsigned LabelW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 18;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_YAW_COSINE     = 3'd0,
    CFG_YAW_SINE       = 3'd1,
    CFG_OFFSET_FORWARD = 3'd2,
    CFG_OFFSET_LEFT    = 3'd3,
    CFG_OFFSET_UP      = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE_PIXEL = 1'b0,
    OP_PROJECT     = 1'b1
  } op_e;

  // intrinsics in Q16, distortion in Q24
  localparam longint FxQ16 = (64'sd1157519519 * 64'sd65536 + 64'sd2000000000) / 64'sd4000000000;
  localparam longint FyQ16 = (64'sd1158977934 * 64'sd65536 + 64'sd2000000000) / 64'sd4000000000;
  localparam longint CxQ16 = (64'sd931165229 * 64'sd65536 + 64'sd2000000000) / 64'sd4000000000;
  localparam longint CyQ16 = (64'sd529569982 * 64'sd65536 + 64'sd2000000000) / 64'sd4000000000;
  localparam longint K1Q24 = (64'sd50773 * 64'sd16777216 + 64'sd500000) / 64'sd1000000;
  localparam longint K2Q24 = -((64'sd106031 * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam longint P1Q24 = -((64'sd1663 * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
  localparam longint P2Q24 = (64'sd80 * 64'sd16777216 + 64'sd500000) / 64'sd1000000;

  localparam longint CamBackMm    = 950;
  localparam longint CamDownMm    = 530;
  localparam longint MinForwardMm = 950;
  localparam longint ZeroDepthDen = 1000 * 16384;

  localparam logic [LabelW-1:0] RejectRing      = 8'd0;
  localparam logic [LabelW-1:0] RejectIntensity = 8'd12;

  // shift right with rounding half away from zero
  function automatic longint rshr(input longint v, input int unsigned n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lpclp_if.sv
// stream and configuration channel interfaces of the lidar label projector
`default_nettype none
interface lpclp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic [lpclp_pkg::PixW-1:0]         pixel_column;
  logic [lpclp_pkg::PixW-1:0]         pixel_row;
  logic [lpclp_pkg::LabelW-1:0]       pixel_object;
  logic [lpclp_pkg::LabelW-1:0]       pixel_class;
  logic signed [lpclp_pkg::CoordW-1:0] point_forward;
  logic signed [lpclp_pkg::CoordW-1:0] point_left;
  logic signed [lpclp_pkg::CoordW-1:0] point_up;
  modport source (output valid, op, pixel_column, pixel_row, pixel_object, pixel_class,
                  point_forward, point_left, point_up, input ready);
  modport sink   (input valid, op, pixel_column, pixel_row, pixel_object, pixel_class,
                  point_forward, point_left, point_up, output ready);
endinterface

interface lpclp_out_if;
  logic                         valid;
  logic                         ready;
  logic [lpclp_pkg::LabelW-1:0] ring_label;
  logic [lpclp_pkg::LabelW-1:0] intensity_label;
  logic                         in_view;
  modport source (output valid, ring_label, intensity_label, in_view, input ready);
  modport sink   (input valid, ring_label, intensity_label, in_view, output ready);
endinterface

interface lpclp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lpclp_pkg::CfgIdxW-1:0] index;
  logic [lpclp_pkg::CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/lidar_point_camera_label_projector.sv
// lidar point to camera label projector: pipelined projection over a label frame memory
// throughput: one item per cycle; the pipeline only halts while a result waits on the output
// label writes travel the same pipeline so the frame memory sees accesses in order
// reset clears valid bits, sets identity yaw and zero offsets; frame is undefined until written
`default_nettype none
module lidar_point_camera_label_projector #(
  parameter int unsigned IMAGE_WIDTH  = lpclp_pkg::ImageWidthDef,
  parameter int unsigned IMAGE_HEIGHT = lpclp_pkg::ImageHeightDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  lpclp_in_if.sink       in_i,
  lpclp_out_if.source    out_o,
  lpclp_cfg_if.sink      cfg_i
);
  import lpclp_pkg::*;

  localparam int unsigned Depth = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned NSt   = 27;
  localparam int unsigned QBits = 18;
  localparam int unsigned RemW  = 53;
  localparam int unsigned DenW  = 35;
  localparam int unsigned CamW  = 35;

  typedef struct packed {
    logic             pt;
    logic             wr_ok;
    logic [AddrW-1:0] waddr;
    logic [15:0]      wdata;
    logic             rej;
  } ctx_t;

  // configuration
  logic signed [TrigW-1:0]  cos_q, sin_q;
  logic signed [CoordW-1:0] off_f_q, off_l_q, off_u_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q   <= 16'sd16384;
      sin_q   <= '0;
      off_f_q <= '0;
      off_l_q <= '0;
      off_u_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_YAW_COSINE:     cos_q   <= cfg_i.data[TrigW-1:0];
        CFG_YAW_SINE:       sin_q   <= cfg_i.data[TrigW-1:0];
        CFG_OFFSET_FORWARD: off_f_q <= cfg_i.data;
        CFG_OFFSET_LEFT:    off_l_q <= cfg_i.data;
        CFG_OFFSET_UP:      off_u_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSt-1:0] vld_q;
  ctx_t           ctx_q [NSt];
  logic           out_valid_q;
  logic           en;

  assign en         = !(out_valid_q && !out_o.ready && vld_q[NSt-1] && ctx_q[NSt-1].pt);
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NSt-2:0], in_i.valid};
      end
      if (en && vld_q[NSt-1] && ctx_q[NSt-1].pt) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage 0: camera coordinates and rejection checks
  ctx_t                   ctx_in;
  logic signed [CamW-1:0] cx_d, cy_d, cz_d, cx_q, cy_q, cz_q;

  always_comb begin
    longint px, py, pz, ax, ay, lin, az;
    px = longint'(in_i.point_forward);
    py = longint'(in_i.point_left);
    pz = longint'(in_i.point_up);
    cx_d = CamW'(longint'(cos_q) * (-py) - longint'(sin_q) * px
                 + (longint'(off_l_q) <<< 14));
    cy_d = CamW'((-pz + longint'(off_u_q) - CamDownMm) <<< 14);
    cz_d = CamW'(longint'(sin_q) * (-py) + longint'(cos_q) * px
                 + ((longint'(off_f_q) - CamBackMm) <<< 14));
    ax  = (px < 0) ? -px : px;
    ay  = (py < 0) ? -py : py;
    lin = 100 * px + 53 * pz;
    lin = (lin < 0) ? -lin : lin;
    az  = (pz < 0) ? -pz : pz;
    ctx_in.pt    = (in_i.op == OP_PROJECT);
    ctx_in.wr_ok = (32'(in_i.pixel_column) < IMAGE_WIDTH)
                && (32'(in_i.pixel_row) < IMAGE_HEIGHT);
    ctx_in.waddr = AddrW'(32'(in_i.pixel_row) * IMAGE_WIDTH + 32'(in_i.pixel_column));
    ctx_in.wdata = {in_i.pixel_class, in_i.pixel_object};
    ctx_in.rej   = (px < MinForwardMm) || (ax <= ay) || (pz != 0 && lin <= 144 * az);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0] <= ctx_in;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      cz_q     <= cz_d;
    end
  end

  for (genvar k = 1; k < NSt; k++) begin : g_ctx
    always_ff @(posedge clk_i) begin
      if (en) ctx_q[k] <= ctx_q[k-1];
    end
  end

  // stage 1: divider set-up, numerator 2|n|+|d| over 2|d|
  logic [RemW-1:0]  rx_q [QBits+1];
  logic [RemW-1:0]  ry_q [QBits+1];
  logic [DenW-1:0]  bd_q [QBits+1];
  logic [QBits-1:0] qx_q [QBits+1];
  logic [QBits-1:0] qy_q [QBits+1];
  logic             nx_q [QBits+1];
  logic             ny_q [QBits+1];
  logic             ox_q [QBits+1];
  logic             oy_q [QBits+1];

  always_ff @(posedge clk_i) begin
    longint den, b, ax, ay, big;
    if (en) begin
      den = (cz_q != 0) ? longint'(cz_q) : ZeroDepthDen;
      b   = (den < 0) ? -den : den;
      ax  = ((cx_q < 0) ? -longint'(cx_q) : longint'(cx_q)) <<< 16;
      ay  = ((cy_q < 0) ? -longint'(cy_q) : longint'(cy_q)) <<< 16;
      ax  = 2 * ax + b;
      ay  = 2 * ay + b;
      big = (2 * b) <<< QBits;
      rx_q[0] <= RemW'(ax);
      ry_q[0] <= RemW'(ay);
      bd_q[0] <= DenW'(2 * b);
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      nx_q[0] <= (cx_q < 0) != (den < 0);
      ny_q[0] <= (cy_q < 0) != (den < 0);
      ox_q[0] <= ax >= big;
      oy_q[0] <= ay >= big;
    end
  end

  // stages 2..19: one quotient bit per stage
  for (genvar j = 0; j < QBits; j++) begin : g_div
    localparam int unsigned Sh = QBits - 1 - j;
    logic [63:0] bsh, rxe, rye;
    logic        gx, gy;
    always_comb begin
      bsh = 64'(bd_q[j]) << Sh;
      rxe = 64'(rx_q[j]);
      rye = 64'(ry_q[j]);
      gx  = rxe >= bsh;
      gy  = rye >= bsh;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rx_q[j+1] <= gx ? RemW'(rxe - bsh) : rx_q[j];
        ry_q[j+1] <= gy ? RemW'(rye - bsh) : ry_q[j];
        qx_q[j+1] <= qx_q[j] | (QBits'(gx) << Sh);
        qy_q[j+1] <= qy_q[j] | (QBits'(gy) << Sh);
        bd_q[j+1] <= bd_q[j];
        nx_q[j+1] <= nx_q[j];
        ny_q[j+1] <= ny_q[j];
        ox_q[j+1] <= ox_q[j];
        oy_q[j+1] <= oy_q[j];
      end
    end
  end

  // stage 20: signed, saturated normalized coordinates and their products
  logic signed [CoordW-1:0] xn20_q, yn20_q;
  logic signed [35:0]       xsq20_q, ysq20_q, xy20_q;

  function automatic longint norm_sat(input logic [QBits-1:0] q, input logic neg,
                                      input logic ovf);
    longint m;
    m = ovf ? longint'(1) << QBits : longint'(q);
    if (neg) return (m > 131072) ? -131072 : -m;
    return (m > 131071) ? 131071 : m;
  endfunction

  always_ff @(posedge clk_i) begin
    longint xn, yn;
    if (en) begin
      xn = norm_sat(qx_q[QBits], nx_q[QBits], ox_q[QBits]);
      yn = norm_sat(qy_q[QBits], ny_q[QBits], oy_q[QBits]);
      xn20_q  <= CoordW'(xn);
      yn20_q  <= CoordW'(yn);
      xsq20_q <= 36'(xn * xn);
      ysq20_q <= 36'(yn * yn);
      xy20_q  <= 36'(xn * yn);
    end
  end

  // stage 21: r squared
  logic signed [CoordW-1:0] xn21_q, yn21_q;
  logic signed [36:0]       r2w21_q, xsq21_q, ysq21_q, xy21_q;
  logic signed [20:0]       r221_q;

  always_ff @(posedge clk_i) begin
    longint r2w;
    if (en) begin
      r2w = longint'(xsq20_q) + longint'(ysq20_q);
      r2w21_q <= 37'(r2w);
      r221_q  <= 21'(rshr(r2w, 16));
      xsq21_q <= 37'(xsq20_q);
      ysq21_q <= 37'(ysq20_q);
      xy21_q  <= 37'(xy20_q);
      xn21_q  <= xn20_q;
      yn21_q  <= yn20_q;
    end
  end

  // stage 22: distortion products
  logic signed [CoordW-1:0] xn22_q, yn22_q;
  logic signed [23:0]       r422_q;
  logic signed [43:0]       k1r2_q;
  logic signed [55:0]       p1xy_q, p2x_q, p1y_q, p2xy_q;

  always_ff @(posedge clk_i) begin
    longint r2;
    if (en) begin
      r2 = longint'(r221_q);
      r422_q <= 24'(rshr(r2 * r2, 16));
      k1r2_q <= 44'(K1Q24 * r2);
      p1xy_q <= 56'(2 * P1Q24 * longint'(xy21_q));
      p2x_q  <= 56'(P2Q24 * (longint'(r2w21_q) + 2 * longint'(xsq21_q)));
      p1y_q  <= 56'(P1Q24 * (longint'(r2w21_q) + 2 * longint'(ysq21_q)));
      p2xy_q <= 56'(2 * P2Q24 * longint'(xy21_q));
      xn22_q <= xn21_q;
      yn22_q <= yn21_q;
    end
  end

  // stage 23: radial factor and tangential terms
  logic signed [CoordW-1:0] xn23_q, yn23_q;
  logic signed [23:0]       rad_q;
  logic signed [31:0]       tx_q, ty_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q  <= 24'(65536 + rshr(longint'(k1r2_q) + K2Q24 * longint'(r422_q), 24));
      tx_q   <= 32'(rshr(longint'(p1xy_q) + longint'(p2x_q), 24));
      ty_q   <= 32'(rshr(longint'(p1y_q) + longint'(p2xy_q), 24));
      xn23_q <= xn22_q;
      yn23_q <= yn22_q;
    end
  end

  // stage 24: distorted coordinates
  logic signed [25:0] xd_q, yd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xd_q <= 26'(rshr(longint'(xn23_q) * longint'(rad_q) + longint'(tx_q), 16));
      yd_q <= 26'(rshr(longint'(yn23_q) * longint'(rad_q) + longint'(ty_q), 16));
    end
  end

  // stage 25: pixel coordinates
  logic signed [17:0] u_q, v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= 18'(rshr(FxQ16 * longint'(xd_q) + (CxQ16 <<< 16), 32));
      v_q <= 18'(rshr(FyQ16 * longint'(yd_q) + (CyQ16 <<< 16), 32));
    end
  end

  // stage 26: frame memory access, writes and reads kept in item order
  logic [15:0]      frame_mem [Depth];
  logic [15:0]      rdata_q;
  logic             ok_d, ok_q;
  logic [AddrW-1:0] raddr;
  ctx_t             c25;

  always_comb begin
    c25   = ctx_q[NSt-2];
    ok_d  = !c25.rej && (u_q >= 0) && (32'(u_q) < IMAGE_WIDTH)
         && (v_q >= 0) && (32'(v_q) < IMAGE_HEIGHT);
    raddr = AddrW'(32'(v_q) * IMAGE_WIDTH + 32'(u_q));
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NSt-2] && !c25.pt && c25.wr_ok) begin
      frame_mem[c25.waddr] <= c25.wdata;
    end
    if (en && vld_q[NSt-2] && c25.pt && ok_d) begin
      rdata_q <= frame_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) ok_q <= ok_d;
  end

  // output register
  logic [LabelW-1:0] ring_q, inten_q;
  logic              view_q;

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NSt-1] && ctx_q[NSt-1].pt) begin
      ring_q  <= ok_q ? rdata_q[7:0]  : RejectRing;
      inten_q <= ok_q ? rdata_q[15:8] : RejectIntensity;
      view_q  <= ok_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.ring_label      = ring_q;
  assign out_o.intensity_label = inten_q;
  assign out_o.in_view         = view_q;

endmodule
`default_nettype wire

FILE: sim/lpclp_label_checker.sv
// label projector checker: watches the channels, predicts each point's labels and compares
module lpclp_label_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lpclp_in_if  in_i,
  lpclp_out_if out_o,
  lpclp_cfg_if cfg_i,
  output int   fail_count_o,
  output int   pending_o
);
  import lpclp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [LabelW-1:0] ring;
    logic [LabelW-1:0] intensity;
    logic              in_view;
  } label_result_t;

  localparam int FrameSize = ImageWidthDef * ImageHeightDef;

  label_result_t labels_due[$];
  logic [15:0]   frame_copy [FrameSize];
  longint        yaw_cos, yaw_sin, off_fwd, off_left, off_up;
  int            fails;

  assign fail_count_o = fails;

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // right shift rounding half away from zero
  function automatic longint round_shift(input longint v, input int n);
    longint m;
    m = (mag64(v) + (longint'(1) << (n - 1))) >> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    longint q;
    q = (2 * mag64(num) + mag64(den)) / (2 * mag64(den));
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint clamp_norm(input longint v);
    if (v < -131072) return -131072;
    if (v > 131071) return 131071;
    return v;
  endfunction

  // camera projection of one point under the current registers
  function automatic void project_point(input logic signed [CoordW-1:0] fwd, left, up,
                                        output int col, output int row, output bit ok);
    longint px, py, pz, cx, cy, cz, den, xn, yn, xsq, ysq, xy;
    longint r2w, r2, r4, rad, xd, yd, uu, vv;
    px = fwd;
    py = left;
    pz = up;
    cx = yaw_cos * (-py) - yaw_sin * px + off_left * 16384;
    cy = (-pz + off_up - CamDownMm) * 16384;
    cz = yaw_sin * (-py) + yaw_cos * px + (off_fwd - CamBackMm) * 16384;
    den = (cz != 0) ? cz : ZeroDepthDen;
    xn = clamp_norm(round_div(cx * 65536, den));
    yn = clamp_norm(round_div(cy * 65536, den));
    xsq = xn * xn;
    ysq = yn * yn;
    xy = xn * yn;
    r2w = xsq + ysq;
    r2 = round_shift(r2w, 16);
    r4 = round_shift(r2 * r2, 16);
    rad = 65536 + round_shift(K1Q24 * r2 + K2Q24 * r4, 24);
    xd = round_shift(xn * rad + round_shift(2 * P1Q24 * xy + P2Q24 * (r2w + 2 * xsq), 24), 16);
    yd = round_shift(yn * rad + round_shift(P1Q24 * (r2w + 2 * ysq) + 2 * P2Q24 * xy, 24), 16);
    uu = round_shift(FxQ16 * xd + CxQ16 * 65536, 32);
    vv = round_shift(FyQ16 * yd + CyQ16 * 65536, 32);
    ok = uu >= 0 && uu < ImageWidthDef && vv >= 0 && vv < ImageHeightDef;
    if (px < MinForwardMm) ok = 0;
    if (mag64(px) <= mag64(py)) ok = 0;
    // viewing cone around the vertical axis
    if (pz != 0 && mag64(100 * px + 53 * pz) <= 144 * mag64(pz)) ok = 0;
    col = int'(uu);
    row = int'(vv);
  endfunction

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int col, row;
    bit ok;
    label_result_t r;
    if (!rst_ni) begin
      labels_due.delete();
      yaw_cos = 16384;
      yaw_sin = 0;
      off_fwd = 0;
      off_left = 0;
      off_up = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_reg_e'(cfg_i.index))
          CFG_YAW_COSINE:     yaw_cos = longint'($signed(cfg_i.data[15:0]));
          CFG_YAW_SINE:       yaw_sin = longint'($signed(cfg_i.data[15:0]));
          CFG_OFFSET_FORWARD: off_fwd = longint'($signed(cfg_i.data));
          CFG_OFFSET_LEFT:    off_left = longint'($signed(cfg_i.data));
          CFG_OFFSET_UP:      off_up = longint'($signed(cfg_i.data));
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) begin
        if (op_e'(in_i.op) == OP_WRITE_PIXEL) begin
          if (in_i.pixel_column < ImageWidthDef && in_i.pixel_row < ImageHeightDef)
            frame_copy[in_i.pixel_row * ImageWidthDef + in_i.pixel_column] =
              {in_i.pixel_class, in_i.pixel_object};
        end else begin
          project_point(in_i.point_forward, in_i.point_left, in_i.point_up, col, row, ok);
          if (ok) begin
            r.ring = frame_copy[row * ImageWidthDef + col][7:0];
            r.intensity = frame_copy[row * ImageWidthDef + col][15:8];
            r.in_view = 1'b1;
          end else begin
            r.ring = RejectRing;
            r.intensity = RejectIntensity;
            r.in_view = 1'b0;
          end
          labels_due = {labels_due, r};
        end
      end
      if (out_o.valid && out_o.ready) begin
        if (labels_due.size() == 0) begin
          report("unexpected result", -1, out_o.ring_label);
        end else begin
          r = labels_due.pop_front();
          if (out_o.ring_label !== r.ring) report("ring_label", r.ring, out_o.ring_label);
          if (out_o.intensity_label !== r.intensity)
            report("intensity_label", r.intensity, out_o.intensity_label);
          if (out_o.in_view !== r.in_view) report("in_view", r.in_view, out_o.in_view);
        end
      end
    end
    pending_o = labels_due.size();
  end

  initial fails = 0;
endmodule

FILE: sim/tb_top.sv
// top of the label projector testbench: clock, reset, stimulus and verdict
module tb_top;
  import lpclp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameSize = ImageWidthDef * ImageHeightDef;
  localparam int Phases = 7;
  localparam int RandomPerPhase = 160;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending;
  bit   calm;
  bit   pixel_written [FrameSize];

  lpclp_in_if  in_ch ();
  lpclp_out_if out_ch ();
  lpclp_cfg_if cfg_ch ();

  lidar_point_camera_label_projector dut (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  lpclp_label_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (calm || p < 45) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // calm stretches with no idling on either side
  initial begin
    calm = 0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk_i);
      calm = ($urandom_range(3) == 0);
    end
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic transfer_item(input op_e op, input int col, input int row,
                               input int obj, input int cls,
                               input int fwd, input int left, input int up);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.pixel_column <= col[PixW-1:0];
    in_ch.pixel_row <= row[PixW-1:0];
    in_ch.pixel_object <= obj[LabelW-1:0];
    in_ch.pixel_class <= cls[LabelW-1:0];
    in_ch.point_forward <= fwd[CoordW-1:0];
    in_ch.point_left <= left[CoordW-1:0];
    in_ch.point_up <= up[CoordW-1:0];
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_pixel(input int col, input int row);
    int c9, r9;
    c9 = col & 511;
    r9 = row & 511;
    if (c9 < ImageWidthDef && r9 < ImageHeightDef) pixel_written[r9 * ImageWidthDef + c9] = 1;
    transfer_item(OP_WRITE_PIXEL, col, row, $urandom_range(255), $urandom_range(255),
                  $urandom, $urandom, $urandom);
  endtask

  // a pixel that would be read before any write gets one first
  task automatic project(input int fwd, input int left, input int up);
    logic signed [CoordW-1:0] f, l, u;
    int col, row;
    bit ok;
    f = fwd[CoordW-1:0];
    l = left[CoordW-1:0];
    u = up[CoordW-1:0];
    chk.project_point(f, l, u, col, row, ok);
    if (ok && !pixel_written[row * ImageWidthDef + col]) write_pixel(col, row);
    transfer_item(OP_PROJECT, $urandom, $urandom, $urandom, $urandom, fwd, left, up);
  endtask

  task automatic aimed_point();
    int d;
    d = $urandom_range(600, 40000);
    project(950 + d, -((int'($urandom_range(1640)) - 820) * d) / 1000,
            -530 - ((int'($urandom_range(940)) - 470) * d) / 1000);
  endtask

  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value[CfgDatW-1:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic cfg_setting(input int c, input int s, input int f, input int l, input int u);
    // spare upper bits of the yaw registers are toggled too
    cfg_write(CFG_YAW_COSINE, (c & 16'hFFFF) | ($urandom_range(3) << 16));
    cfg_write(CFG_YAW_SINE, (s & 16'hFFFF) | ($urandom_range(3) << 16));
    cfg_write(CFG_OFFSET_FORWARD, f);
    cfg_write(CFG_OFFSET_LEFT, l);
    cfg_write(CFG_OFFSET_UP, u);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int p;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE_PIXEL;
    in_ch.pixel_column = '0;
    in_ch.pixel_row = '0;
    in_ch.pixel_object = '0;
    in_ch.pixel_class = '0;
    in_ch.point_forward = '0;
    in_ch.point_left = '0;
    in_ch.point_up = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_YAW_COSINE;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners of the frame and addresses outside it
    transfer_item(OP_WRITE_PIXEL, 0, 0, 255, 255, 0, 0, 0);
    pixel_written[0] = 1;
    transfer_item(OP_WRITE_PIXEL, 479, 269, 0, 0, 0, 0, 0);
    pixel_written[FrameSize - 1] = 1;
    write_pixel(511, 511);
    write_pixel(480, 0);
    write_pixel(0, 270);
    project(950, 0, 0);                // zero depth
    project(951, 0, -600);
    project(949, 0, -530);             // just short of the minimum forward distance
    project(2000, 2000, -600);         // |forward| equal to |left|
    project(2000, 0, -3000);           // outside the vertical cone
    project(3000, 0, 0);               // up zero
    project(131071, 131071, 131071);
    project(-131072, -131072, -131072);
    project(131071, -131072, 0);
    project(131071, 0, -131072);
    project(960, -959, 0);             // normalized coordinates saturate
    project(960, 0, -100000);
    project(5000, 4000, -5000);
    project(-5000, 0, 0);
    aimed_point();
    aimed_point();

    for (int ph = 0; ph < Phases; ph++) begin
      if (ph > 0) quiesce();
      case (ph)
        1: cfg_setting(16384, 0, 0, 0, 0);
        2: cfg_setting(15137, 6270, 100, -200, 50);
        3: cfg_setting(-16384, 16384, 131071, -131072, 131071);
        4: cfg_setting(16384, -16384, -131072, 131071, -131072);
        5: cfg_setting($urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                       $urandom_range(1000) - 500, $urandom_range(1000) - 500,
                       $urandom_range(1000) - 500);
        6: cfg_setting(16384, 0, 300, 0, 0);
        default: ;
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        p = $urandom_range(99);
        if (p < 25) begin
          if ($urandom_range(9) == 0) write_pixel($urandom, $urandom);
          else write_pixel($urandom_range(ImageWidthDef - 1), $urandom_range(ImageHeightDef - 1));
        end else if (p < 80) begin
          aimed_point();
        end else begin
          project($urandom, $urandom, $urandom);
        end
      end
    end

    quiesce();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
